// ===== hw/rtl/g3f_pkg.sv =====
// Shared constants, types and register codes of the 3x3 image filter.
package g3f_pkg;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int H_W    = 13;
	localparam int IW_W   = 11;
	localparam int CFG_W  = 48;
	localparam int CIDX_W = 3;
	localparam int TAP_W  = 16;
	localparam int PROD_W = TAP_W + PIX_W + 1;
	localparam int RSUM_W = PROD_W + 2;
	localparam int SUM_W  = RSUM_W + 2;

	localparam int MAX_HEIGHT         = 4096;
	localparam int DEF_MAX_WIDTH      = 1024;
	localparam int DEF_COEF_FRAC_BITS = 14;

	localparam logic [CFG_W-1:0] RST_COEF_TOP = 48'h0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_COEF_MID = 48'h0000_4000_0000;
	localparam logic [CFG_W-1:0] RST_COEF_BOT = 48'h0000_0000_0000;
	localparam logic [IW_W-1:0]  RST_IMG_W    = 11'd1024;
	localparam logic [H_W-1:0]   RST_IMG_H    = 13'd1024;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

	typedef enum logic [CIDX_W-1:0] {
		CFG_COEF_TOP = 3'd0,
		CFG_COEF_MID = 3'd1,
		CFG_COEF_BOT = 3'd2,
		CFG_IMG_W    = 3'd3,
		CFG_IMG_H    = 3'd4
	} cfg_idx_t;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [RSUM_W-1:0] rsum_t;

	// Per-pixel bookkeeping that travels down the pipeline.
	typedef struct packed {
		logic             filt;
		logic             bord;
		logic [PIX_W-1:0] px;
		logic [ROW_W-1:0] row;
	} meta_t;

endpackage

// ===== hw/rtl/g3f_pix_if.sv =====
// Source pixel channel of the 3x3 image filter.
interface g3f_pix_if import g3f_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

// ===== hw/rtl/g3f_res_if.sv =====
// Result channel of the 3x3 image filter.
interface g3f_res_if import g3f_pkg::*; #(
	parameter int COL_W = $clog2(DEF_MAX_WIDTH)
);
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             run_last;

	modport source (output valid, output pixel_out, output out_row, output out_col,
		output run_last, input ready);
	modport sink (input valid, input pixel_out, input out_row, input out_col,
		input run_last, output ready);
endinterface

// ===== hw/rtl/g3f_cfg_if.sv =====
// Configuration write channel of the 3x3 image filter.
interface g3f_cfg_if import g3f_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CFG_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/g3f_line_buf.sv =====
// Two-line buffer memory with a registered read and write-to-read forwarding.
module g3f_line_buf import g3f_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic                   wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [2*PIX_W-1:0]     wr_data,
	output logic [2*PIX_W-1:0]     rd_data
);

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] mem_rd_q;
	logic [2*PIX_W-1:0] fwd_data_q;
	logic               fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// A read issued on the same edge as a write to the same entry sees the old
	// contents, so the written word is captured and used instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : mem_rd_q;

endmodule

// ===== hw/rtl/g3f_mac.sv =====
// Kernel multiply stage and row-sum stage of the 3x3 image filter.
module g3f_mac import g3f_pkg::*; #(
	parameter int COL_W = $clog2(DEF_MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] coef [3],
	input  logic             v_in,
	output logic             rdy_in,
	input  meta_t            meta_in,
	input  logic [COL_W-1:0] col_in,
	input  logic [PIX_W-1:0] pix [3][3],
	output logic             v_out,
	input  logic             rdy_out,
	output meta_t            meta_out,
	output logic [COL_W-1:0] col_out,
	output rsum_t            rsum [3]
);

	prod_t            prod_d [3][3];
	prod_t            prod_s2 [3][3];
	meta_t            meta_s2;
	logic [COL_W-1:0] col_s2;
	logic             v_s2;
	rsum_t            rsum_d [3];
	rsum_t            rsum_s3 [3];
	meta_t            meta_s3;
	logic [COL_W-1:0] col_s3;
	logic             v_s3;
	logic             en_s2;
	logic             en_s3;

	assign en_s3  = !v_s3 || rdy_out;
	assign en_s2  = !v_s2 || en_s3;
	assign rdy_in = en_s2;

	// Left tap sits in the top 16 bits of each row register.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				prod_d[k][j] = $signed(coef[k][CFG_W-1-TAP_W*j -: TAP_W])
					* $signed({1'b0, pix[k][j]});
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rsum_d[k] = RSUM_W'(prod_s2[k][0]) + RSUM_W'(prod_s2[k][1])
				+ RSUM_W'(prod_s2[k][2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			// Pixels that yield no result end their trip here.
			if (en_s2) begin
				v_s2 <= v_in && (meta_in.filt || meta_in.bord);
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= prod_d;
			meta_s2 <= meta_in;
			col_s2  <= col_in;
		end
		if (en_s3) begin
			rsum_s3 <= rsum_d;
			meta_s3 <= meta_s2;
			col_s3  <= col_s2;
		end
	end

	assign v_out    = v_s3;
	assign meta_out = meta_s3;
	assign col_out  = col_s3;
	assign rsum     = rsum_s3;

endmodule

// ===== hw/rtl/g3f_out.sv =====
// Final sum, clamp and result sequencing of the 3x3 image filter.
module g3f_out import g3f_pkg::*; #(
	parameter int COL_W          = $clog2(DEF_MAX_WIDTH),
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_in,
	output logic             rdy_in,
	input  meta_t            meta_in,
	input  logic [COL_W-1:0] col_in,
	input  rsum_t            rsum [3],
	g3f_res_if.source        res
);

	logic signed [SUM_W-1:0] total;
	logic [SUM_W-1:0]        quot;
	logic [PIX_W-1:0]        val_d;
	logic                    o_valid_q;
	logic                    o_phase_q;
	meta_t                   o_meta_q;
	logic [COL_W-1:0]        o_col_q;
	logic [PIX_W-1:0]        o_val_q;
	logic                    show_filt;
	logic                    last;

	always_comb begin
		total = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
		quot  = SUM_W'(total >>> COEF_FRAC_BITS);
		if (total[SUM_W-1]) begin
			val_d = '0;
		end else if (|quot[SUM_W-1:PIX_W]) begin
			val_d = PIX_MAX;
		end else begin
			val_d = quot[PIX_W-1:0];
		end
	end

	// The filtered result of the neighbor goes out first, the border copy second.
	assign show_filt = o_meta_q.filt && !o_phase_q;
	assign last      = !(show_filt && o_meta_q.bord);
	assign rdy_in    = !o_valid_q || (res.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			o_phase_q <= 1'b0;
		end else if (rdy_in) begin
			o_valid_q <= v_in;
			o_phase_q <= 1'b0;
		end else if (res.ready) begin
			o_phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_in) begin
			o_meta_q <= meta_in;
			o_col_q  <= col_in;
			o_val_q  <= val_d;
		end
	end

	assign res.valid     = o_valid_q;
	assign res.pixel_out = show_filt ? o_val_q : o_meta_q.px;
	assign res.out_row   = show_filt ? o_meta_q.row - ROW_W'(1) : o_meta_q.row;
	assign res.out_col   = show_filt ? o_col_q - COL_W'(1) : o_col_q;
	assign res.run_last  = last;

endmodule

// ===== hw/rtl/gauss_3x3_image_filter.sv =====
// Top level of the streaming 3x3 convolution image filter.
//
//   Channel   Modport  Beat carries                              Handshake
//   pixels    sink     pixel_in, one source pixel, raster order  valid/ready
//   results   source   pixel_out, out_row, out_col, run_last     valid/ready
//   cfg       sink     index, data (register write)              valid/ready
//
// One pixel is taken per clock while the pipeline does not stall; the result
// port sends one beat per clock while its ready is high, so a pixel that
// yields both a filtered neighbor and its own border copy holds the output for
// both beats. The line-buffer memory and its read latency set the pipeline
// front; the multipliers and adders fill the next three stages. Reset clears
// counters, window and valid flags but not the line buffer, which is read at
// each pixel's column even before the current frame has written that entry.
// Stages advance independently, so bubbles fill while the result port stalls.
module gauss_3x3_image_filter import g3f_pkg::*; #(
	parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	g3f_pix_if.sink   pixels,
	g3f_res_if.source results,
	g3f_cfg_if.sink   cfg
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int EW    = (WW > IW_W) ? WW : IW_W;

	// Configuration registers.
	logic [CFG_W-1:0] coef_q [3];
	logic [IW_W-1:0]  img_w_q;
	logic [H_W-1:0]   img_h_q;

	// Position of the next pixel.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Effective geometry and position of the pixel being taken.
	logic [EW-1:0]    iw_ext;
	logic [WW-1:0]    w_eff;
	logic [H_W-1:0]   h_eff;
	logic             col_wrap;
	logic [H_W-1:0]   r_adv;
	logic [ROW_W-1:0] r0;
	logic [COL_W-1:0] c0;
	logic [WW-1:0]    c_next;
	logic [H_W-1:0]   r_next;
	logic             row_end;
	logic [COL_W-1:0] col_d;
	logic [ROW_W-1:0] row_d;
	meta_t            meta_d;
	logic             accept;

	// First pipeline stage: line-buffer data arrives here.
	logic             v_s1;
	meta_t            meta_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] win_q [6];
	logic [2*PIX_W-1:0] line_rd;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;
	logic [PIX_W-1:0] pix_s1 [3][3];
	logic             adv_s1;

	logic             mac_rdy;
	logic             mac_v;
	meta_t            mac_meta;
	logic [COL_W-1:0] mac_col;
	rsum_t            mac_rsum [3];
	logic             out_rdy;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= RST_COEF_TOP;
			coef_q[1] <= RST_COEF_MID;
			coef_q[2] <= RST_COEF_BOT;
			img_w_q   <= RST_IMG_W;
			img_h_q   <= RST_IMG_H;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_COEF_TOP: coef_q[0] <= cfg.data;
				CFG_COEF_MID: coef_q[1] <= cfg.data;
				CFG_COEF_BOT: coef_q[2] <= cfg.data;
				CFG_IMG_W:    img_w_q   <= cfg.data[IW_W-1:0];
				CFG_IMG_H:    img_h_q   <= cfg.data[H_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Geometry saturates to 1..MAX_WIDTH and 1..MAX_HEIGHT. The counters are
	// folded back first in case the geometry shrank between frames.
	always_comb begin
		iw_ext = EW'(img_w_q);
		if (iw_ext == '0) begin
			w_eff = WW'(1);
		end else if (iw_ext > EW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(iw_ext);
		end
		if (img_h_q == '0) begin
			h_eff = H_W'(1);
		end else if (img_h_q > H_W'(MAX_HEIGHT)) begin
			h_eff = H_W'(MAX_HEIGHT);
		end else begin
			h_eff = img_h_q;
		end

		col_wrap = WW'(col_q) >= w_eff;
		r_adv    = H_W'(row_q) + H_W'(col_wrap);
		r0       = (r_adv >= h_eff) ? '0 : r_adv[ROW_W-1:0];
		c0       = col_wrap ? '0 : col_q;

		c_next  = WW'(c0) + WW'(1);
		r_next  = H_W'(r0) + H_W'(1);
		row_end = c_next >= w_eff;
		col_d   = row_end ? '0 : c_next[COL_W-1:0];
		if (!row_end) begin
			row_d = r0;
		end else if (r_next >= h_eff) begin
			row_d = '0;
		end else begin
			row_d = r_next[ROW_W-1:0];
		end

		meta_d.filt = (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
		meta_d.bord = (r0 == '0) || (r_next == h_eff) || (c0 == '0) || (c_next == w_eff);
		meta_d.px   = pixels.pixel_in;
		meta_d.row  = r0;
	end

	assign pixels.ready = !v_s1 || mac_rdy;
	assign accept       = pixels.valid && pixels.ready;
	assign adv_s1       = v_s1 && mac_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept) begin
				col_q <= col_d;
				row_q <= row_d;
				v_s1  <= 1'b1;
			end else if (mac_rdy) begin
				v_s1  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_d;
			col_s1  <= c0;
		end
	end

	// Each entry holds the two rows above its column: row r-2 in the upper
	// byte, row r-1 in the lower. Leaving stage one shifts both down a row.
	g3f_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (c0),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data ({mid_s1, meta_s1.px}),
		.rd_data (line_rd)
	);

	assign top_s1 = line_rd[2*PIX_W-1:PIX_W];
	assign mid_s1 = line_rd[PIX_W-1:0];

	// The window keeps the two previous columns of the three rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= meta_s1.px;
		end
	end

	always_comb begin
		pix_s1[0][0] = win_q[0];
		pix_s1[0][1] = win_q[3];
		pix_s1[0][2] = top_s1;
		pix_s1[1][0] = win_q[1];
		pix_s1[1][1] = win_q[4];
		pix_s1[1][2] = mid_s1;
		pix_s1[2][0] = win_q[2];
		pix_s1[2][1] = win_q[5];
		pix_s1[2][2] = meta_s1.px;
	end

	g3f_mac #(
		.COL_W (COL_W)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef_q),
		.v_in     (v_s1),
		.rdy_in   (mac_rdy),
		.meta_in  (meta_s1),
		.col_in   (col_s1),
		.pix      (pix_s1),
		.v_out    (mac_v),
		.rdy_out  (out_rdy),
		.meta_out (mac_meta),
		.col_out  (mac_col),
		.rsum     (mac_rsum)
	);

	g3f_out #(
		.COL_W          (COL_W),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_in    (mac_v),
		.rdy_in  (out_rdy),
		.meta_in (mac_meta),
		.col_in  (mac_col),
		.rsum    (mac_rsum),
		.res     (results)
	);

	// A filtered result that is not the last of its pixel is followed at once
	// by the border copy of the same pixel.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.ready && !results.run_last
		|=> results.valid && results.run_last)
		else $error("border copy did not follow a filtered result");

	// A filtered result that is not the last of its pixel never lies in the first row or column.
	a_filt_interior: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.run_last
		|-> results.out_row != '0 && results.out_col != '0)
		else $error("filtered result on the image border");

	// An accepted pixel always occupies the line-buffer stage next cycle.
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && pixels.ready |=> v_s1)
		else $error("accepted pixel lost before the line-buffer stage");

endmodule

// ===== dv/gauss_filter_checker.sv =====
// Channel monitor, filter predictor and result comparison for the 3x3 image filter.
module gauss_filter_checker import g3f_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	g3f_pix_if   pix,
	g3f_res_if   res,
	g3f_cfg_if   cfg,
	output int   mismatches,
	output int   due_count,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COL_W = $clog2(DEF_MAX_WIDTH);

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} out_beat_t;

	logic [CFG_W-1:0] k_top, k_mid, k_bot;
	logic [IW_W-1:0]  img_w;
	logic [H_W-1:0]   img_h;
	logic [PIX_W-1:0] line_r1 [DEF_MAX_WIDTH];
	logic [PIX_W-1:0] line_r2 [DEF_MAX_WIDTH];
	logic [PIX_W-1:0] win [6];
	int unsigned      row_at, col_at;
	out_beat_t        due_pixels [$];
	out_beat_t        want;
	int               n_bad, n_checked;

	// Weighted sum of three pixels with the left, center and right taps of one kernel row.
	function automatic longint row_dot(input logic [CFG_W-1:0] taps,
			input logic [PIX_W-1:0] a, b, c);
		return longint'($signed(taps[2*TAP_W +: TAP_W])) * longint'(a)
			+ longint'($signed(taps[TAP_W +: TAP_W])) * longint'(b)
			+ longint'($signed(taps[0 +: TAP_W])) * longint'(c);
	endfunction

	// Advances the raster position by one source pixel and queues the beats it causes.
	task automatic filter_pixel(input logic [PIX_W-1:0] px);
		int unsigned      w, h, r, c;
		logic [PIX_W-1:0] up2, up1;
		longint           acc, q;
		out_beat_t        filt, bord;
		logic             has_filt, has_bord;

		w = img_w;
		if (w < 1) w = 1;
		if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
		h = img_h;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;

		// A geometry change can leave the counters outside the new frame.
		if (col_at >= w) begin
			col_at = 0;
			row_at++;
		end
		if (row_at >= h) row_at = 0;
		r = row_at;
		c = col_at;

		up2 = line_r2[c];
		up1 = line_r1[c];

		has_filt = (r >= 2) && (c >= 2);
		if (has_filt) begin
			acc = row_dot(k_top, win[0], win[3], up2)
				+ row_dot(k_mid, win[1], win[4], up1)
				+ row_dot(k_bot, win[2], win[5], px);
			if (acc < 0) begin
				q = 0;
			end else begin
				q = acc >>> DEF_COEF_FRAC_BITS;
				if (q > longint'(PIX_MAX)) q = longint'(PIX_MAX);
			end
			filt = '{pix: PIX_W'(q), row: ROW_W'(r - 1), col: COL_W'(c - 1), last: 1'b0};
		end

		has_bord = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
		bord = '{pix: px, row: ROW_W'(r), col: COL_W'(c), last: 1'b1};

		if (has_filt) begin
			filt.last = !has_bord;
			due_pixels.push_back(filt);
		end
		if (has_bord) due_pixels.push_back(bord);

		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = up2;
		win[4] = up1;
		win[5] = px;
		line_r2[c] = up1;
		line_r1[c] = px;

		col_at = c + 1;
		if (col_at >= w) begin
			col_at = 0;
			row_at = r + 1;
			if (row_at >= h) row_at = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_top = RST_COEF_TOP;
			k_mid = RST_COEF_MID;
			k_bot = RST_COEF_BOT;
			img_w = RST_IMG_W;
			img_h = RST_IMG_H;
			foreach (line_r1[i]) begin
				line_r1[i] = '0;
				line_r2[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			row_at = 0;
			col_at = 0;
			due_pixels.delete();
			n_bad = 0;
			n_checked = 0;
		end else begin
			// Results leave only after their pixel has passed the pipeline registers, so the pop goes first.
			if (res.valid && res.ready) begin
				if (due_pixels.size() == 0) begin
					n_bad++;
					$display("%0t: unexpected result beat: pixel %0d at (%0d,%0d) last %0b",
						$time, res.pixel_out, res.out_row, res.out_col, res.run_last);
				end else begin
					want = due_pixels.pop_front();
					n_checked++;
					if (res.pixel_out !== want.pix || res.out_row !== want.row
							|| res.out_col !== want.col || res.run_last !== want.last) begin
						n_bad++;
						$display("%0t: expected pixel %0d at (%0d,%0d) last %0b, got %0d at (%0d,%0d) last %0b",
							$time, want.pix, want.row, want.col, want.last,
							res.pixel_out, res.out_row, res.out_col, res.run_last);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_COEF_TOP: k_top = cfg.data;
					CFG_COEF_MID: k_mid = cfg.data;
					CFG_COEF_BOT: k_bot = cfg.data;
					CFG_IMG_W:    img_w = cfg.data[IW_W-1:0];
					CFG_IMG_H:    img_h = cfg.data[H_W-1:0];
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) filter_pixel(pix.pixel_in);
		end
		mismatches <= n_bad;
		due_count <= due_pixels.size();
		checked <= n_checked;
	end

endmodule

// ===== dv/tb_gauss_3x3_image_filter.sv =====
// Testbench top of the 3x3 image filter: clock, reset, stimulus, pacing and verdict.
module tb_gauss_3x3_image_filter import g3f_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// A pixel that causes no result can still sit in the pipeline after the last
	// beat has come, so every register write waits this many quiet cycles first.
	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 350;

	// Register indexes above the last decoded one must be ignored by the block.
	localparam logic [CIDX_W-1:0] CFG_IDX_SPARE = CIDX_W'(CFG_IMG_H + 1);

	// Q2.14 taps: saturating extremes and the 1-2-1 Gaussian weights (1/16 steps).
	localparam logic [TAP_W-1:0] TAP_MAX_POS = 16'h7FFF;
	localparam logic [TAP_W-1:0] TAP_MAX_NEG = 16'h8000;
	localparam logic [TAP_W-1:0] TAP_G1      = 16'h0400;
	localparam logic [TAP_W-1:0] TAP_G2      = 16'h0800;
	localparam logic [TAP_W-1:0] TAP_G4      = 16'h1000;

	typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

	logic        clk;
	logic        arst_n;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int          pixels_sent = 0;
	int          n_bad, n_due, n_checked;

	g3f_pix_if pix_ch();
	g3f_res_if res_ch();
	g3f_cfg_if cfg_ch();

	gauss_3x3_image_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// The checker sees every beat on all three channels, predicts the results
	// and hands back its mismatch count and the number of results still due.
	gauss_filter_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.mismatches (n_bad),
		.due_count  (n_due),
		.checked    (n_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#1_000_000;
		$display("gauss_3x3_image_filter: mismatch");
		$finish;
	end

	// The result side stalls at random with the probability of the current pace.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FULL:      begin idle_pct = 0;  stall_pct = 0;  end
			PACE_SRC_IDLE:  begin idle_pct = 85; stall_pct = 0;  end
			PACE_SNK_STALL: begin idle_pct = 0;  stall_pct = 85; end
			PACE_BOTH:      begin idle_pct = 15; stall_pct = 15; end
			default: ;
		endcase
	endtask

	// One register write. The channel is left quiet for a cycle after its beat,
	// so back-to-back writes never raise and lower valid in the same step.
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one pixel, after random idle cycles, and returns at the edge that
	// takes the beat. Valid stays high so the next pixel can follow at once.
	task automatic send_pixel(input logic [PIX_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_in <= v;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		pixels_sent++;
	endtask

	// Stops the pixel stream, waits for every predicted result to arrive and
	// then lets the pipeline run empty.
	task automatic quiesce();
		int guard;
		guard = 0;
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_due != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A stretch of random pixels; at beat pause_at the sender waits until the
	// block has delivered everything it owes.
	task automatic send_run(input int count, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at) quiesce();
			send_pixel(PIX_W'($urandom));
		end
	endtask

	// One kernel row: mostly moderate taps so that sums land inside 0..255,
	// sometimes a raw 16-bit tap that drives the clamp either way.
	function automatic logic [CFG_W-1:0] random_taps();
		logic [CFG_W-1:0] taps;
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(3) == 0)
				taps[k*TAP_W +: TAP_W] = TAP_W'($urandom);
			else
				taps[k*TAP_W +: TAP_W] = TAP_W'(int'($urandom_range(6144)) - 1024);
		end
		return taps;
	endfunction

	initial begin
		int               p, n, rand_sent;
		logic [CFG_W-1:0] data;

		arst_n <= 1'b0;
		pix_ch.valid <= 1'b0;
		pix_ch.pixel_in <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_COEF_TOP;
		cfg_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three full rows at the reset geometry and identity kernel. Besides the
		// widest columns this defines every line-buffer entry, so later width
		// changes never make the block read an entry that was never written.
		set_pace(PACE_FULL);
		send_run(3 * DEF_MAX_WIDTH, -1);
		quiesce();

		// Gaussian kernel on a 3x3 frame with a checkerboard of the extremes;
		// the center sums to 127.5 and must floor. Shrinking the height now
		// wraps the row counter, which sits in row 3 of the large frame.
		write_reg(CFG_IMG_W, 3);
		write_reg(CFG_IMG_H, 3);
		write_reg(CFG_COEF_TOP, {TAP_G1, TAP_G2, TAP_G1});
		write_reg(CFG_COEF_MID, {TAP_G2, TAP_G4, TAP_G2});
		write_reg(CFG_COEF_BOT, {TAP_G1, TAP_G2, TAP_G1});
		for (int i = 0; i < 9; i++) send_pixel((i % 2) ? '0 : PIX_MAX);
		quiesce();

		// A 3x4 frame: the first interior pixel under the largest positive taps
		// clamps high, the second under the most negative taps clamps to zero.
		write_reg(CFG_IMG_H, 4);
		write_reg(CFG_COEF_TOP, {3{TAP_MAX_POS}});
		write_reg(CFG_COEF_MID, {3{TAP_MAX_POS}});
		write_reg(CFG_COEF_BOT, {3{TAP_MAX_POS}});
		for (int i = 0; i < 9; i++) send_pixel(PIX_MAX);
		quiesce();
		write_reg(CFG_COEF_TOP, {3{TAP_MAX_NEG}});
		write_reg(CFG_COEF_MID, {3{TAP_MAX_NEG}});
		write_reg(CFG_COEF_BOT, {3{TAP_MAX_NEG}});
		send_run(3, -1);
		quiesce();

		// A frame too small to have an interior, width 2 with height zero, which
		// counts as one row; then all-ones registers that saturate both sizes.
		write_reg(CFG_IMG_W, 2);
		write_reg(CFG_IMG_H, 0);
		send_run(3, -1);
		quiesce();
		write_reg(CFG_IMG_W, '1);
		write_reg(CFG_IMG_H, '1);
		for (int i = CFG_IDX_SPARE; i < 2 ** CIDX_W; i++) write_reg(CIDX_W'(i), '1);
		send_run(3, -1);
		quiesce();

		// Width zero counts as one column, so every pixel is a border pixel; a
		// full 4096-row frame takes the row index to its top and back to zero.
		write_reg(CFG_IMG_W, 0);
		send_run(MAX_HEIGHT + 8, -1);
		quiesce();

		// Random phases: random kernels and small geometries written between
		// runs, so changes land mid-frame, and the four pacing modes in turn.
		p = 0;
		rand_sent = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			set_pace(pace_t'(p % 4));
			for (int k = 0; k < 3; k++)
				if (p == 0 || $urandom_range(1) == 1)
					write_reg(CIDX_W'(CFG_COEF_TOP + k), random_taps());
			if (p == 0 || $urandom_range(2) == 0) begin
				data = ($urandom_range(1) == 1) ? CFG_W'({$urandom, $urandom}) : '0;
				data[IW_W-1:0] = IW_W'($urandom_range(9));
				write_reg(CFG_IMG_W, data);
			end
			if (p == 0 || $urandom_range(2) == 0) begin
				data = ($urandom_range(1) == 1) ? CFG_W'({$urandom, $urandom}) : '0;
				if ($urandom_range(7) == 0)
					data[H_W-1:0] = H_W'($urandom);
				else
					data[H_W-1:0] = H_W'($urandom_range(7));
				write_reg(CFG_IMG_H, data);
			end
			n = $urandom_range(12, 40);
			send_run(n, (p % 3 == 1) ? int'($urandom_range(1, n - 1)) : -1);
			rand_sent += n;
			quiesce();
			p++;
		end

		$display("Covered %0d pixels and %0d result beats: full-width and 4096-row frames,",
			pixels_sent, n_checked);
		$display("tiny and saturated sizes, clamping and random kernels, idle and stall pacing.");
		if (n_due != 0) $display("%0d expected results never arrived", n_due);
		if (n_bad == 0 && n_due == 0) begin
			$display("gauss_3x3_image_filter: match");
		end else begin
			$display("gauss_3x3_image_filter: mismatch");
		end
		$finish;
	end

endmodule
